/* hw/rtl/ufmms_pkg.sv */
package ufmms_pkg;

  // fixed field widths of the command and result words
  localparam int ELEM_W = 10;
  localparam int CNT_W  = 11;

  localparam int DEF_NUM_ELEMENTS = 1024;

  // largest set size that a count can record
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // operation codes
  localparam logic [1:0] OP_UNION = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_MAKE  = 2'd2;

endpackage

/* hw/rtl/ufmms_ram.sv */
module ufmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ufmms_merge.sv */
module ufmms_merge #(
  parameter int AW = 10
) (
  input  logic [ufmms_pkg::CNT_W-1:0] cnt_a,
  input  logic [AW-1:0]               lo_a,
  input  logic [AW-1:0]               hi_a,
  input  logic [ufmms_pkg::CNT_W-1:0] cnt_b,
  input  logic [AW-1:0]               lo_b,
  input  logic [AW-1:0]               hi_b,
  output logic                        b_wins,
  output logic [ufmms_pkg::CNT_W-1:0] cnt_sum,
  output logic [AW-1:0]               lo,
  output logic [AW-1:0]               hi
);

  logic [ufmms_pkg::CNT_W:0] sum;

  // strictly larger second set takes the root, a tie stays with the first
  assign b_wins = cnt_a < cnt_b;

  // saturating count add
  assign sum     = {1'b0, cnt_a} + {1'b0, cnt_b};
  assign cnt_sum = sum[ufmms_pkg::CNT_W] ? ufmms_pkg::CNT_MAX : sum[ufmms_pkg::CNT_W-1:0];

  assign lo = (lo_b < lo_a) ? lo_b : lo_a;
  assign hi = (hi_b > hi_a) ? hi_b : hi_a;

endmodule

/* hw/rtl/union_find_min_max_size.sv */
// Union-find table with set size, min and max, one command word at a time.
// A command is taken at a clock edge where start is high and busy is low;
// busy stays high while it runs. A get reports its result for exactly one
// cycle on set_min, set_max and set_size with done high; there is no way to
// hold a result off, so the receiver must take it in that cycle. After reset
// the block sweeps both tables back to singletons, one entry per cycle, so
// busy is high through the whole sweep and no command is taken before it ends.
// Timing is set by the single read port of the parent table, walked twice per
// find (once to the root, once to compress), over a path of k links each time.
// A get's result appears in the same cycle that busy falls. A union whose two
// elements already share a root ends after compression, with no merge. A
// make-set is busy one cycle. An unused op code or an element not below
// NUM_ELEMENTS is accepted and dropped without busy rising. With union by
// size, k stays near log2 of the set size.
module union_find_min_max_size #(
  parameter int NUM_ELEMENTS = ufmms_pkg::DEF_NUM_ELEMENTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op,
  input  logic [ufmms_pkg::ELEM_W-1:0] elem_a,
  input  logic [ufmms_pkg::ELEM_W-1:0] elem_b,
  output logic                         done,
  output logic [ufmms_pkg::ELEM_W-1:0] set_min,
  output logic [ufmms_pkg::ELEM_W-1:0] set_max,
  output logic [ufmms_pkg::CNT_W-1:0]  set_size
);

  localparam int AW    = $clog2(NUM_ELEMENTS);
  localparam int CW    = ufmms_pkg::CNT_W;
  localparam int EW    = ufmms_pkg::ELEM_W;
  localparam int IW    = CW + 2 * AW;
  localparam int XW    = (AW > EW) ? AW : EW;

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WALK_RD  = 4'd2;
  localparam logic [3:0] S_WALK_CHK = 4'd3;
  localparam logic [3:0] S_COMP_RD  = 4'd4;
  localparam logic [3:0] S_COMP_WR  = 4'd5;
  localparam logic [3:0] S_INFO_A   = 4'd6;
  localparam logic [3:0] S_INFO_B   = 4'd7;
  localparam logic [3:0] S_MERGE    = 4'd8;
  localparam logic [3:0] S_GET      = 4'd9;
  localparam logic [3:0] S_MAKE     = 4'd10;

  logic [3:0]    state;
  logic [1:0]    op_q;
  logic          phase;      // 0 while finding elem_a's root, 1 for elem_b
  logic [AW-1:0] clr;        // sweep index after reset
  logic [AW-1:0] fe;         // element the running find started from
  logic [AW-1:0] r;          // walk position, then the root
  logic [AW-1:0] cur;        // compression position
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [AW-1:0] b_q;
  logic [IW-1:0] info_a;     // info word of the first root

  // element ports to table addresses
  logic [XW-1:0] a_x;
  logic [XW-1:0] b_x;
  logic          a_ok;
  logic          b_ok;
  logic          accept;

  assign a_x    = XW'(elem_a);
  assign b_x    = XW'(elem_b);
  assign a_ok   = 32'(elem_a) < 32'(NUM_ELEMENTS);
  assign b_ok   = 32'(elem_b) < 32'(NUM_ELEMENTS);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // parent table port
  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [AW-1:0] p_wdata;
  logic [AW-1:0] p_raddr;
  logic [AW-1:0] p_rdata;

  // info table port: {count, lowest, highest}
  logic          i_we;
  logic [AW-1:0] i_waddr;
  logic [IW-1:0] i_wdata;
  logic [AW-1:0] i_raddr;
  logic [IW-1:0] i_rdata;

  ufmms_ram #(.WIDTH(AW), .DEPTH(NUM_ELEMENTS)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ufmms_ram #(.WIDTH(IW), .DEPTH(NUM_ELEMENTS)) u_info (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (i_wdata),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  // field views of the info words
  logic [CW-1:0] cnt_a;
  logic [AW-1:0] lo_a;
  logic [AW-1:0] hi_a;
  logic [CW-1:0] cnt_b;
  logic [AW-1:0] lo_b;
  logic [AW-1:0] hi_b;

  assign cnt_a = info_a[IW-1 -: CW];
  assign lo_a  = info_a[2*AW-1 -: AW];
  assign hi_a  = info_a[AW-1:0];
  assign cnt_b = i_rdata[IW-1 -: CW];
  assign lo_b  = i_rdata[2*AW-1 -: AW];
  assign hi_b  = i_rdata[AW-1:0];

  logic          b_wins;
  logic [CW-1:0] m_cnt;
  logic [AW-1:0] m_lo;
  logic [AW-1:0] m_hi;

  // the combine unit for two roots
  ufmms_merge #(.AW(AW)) u_merge (
    .cnt_a   (cnt_a),
    .lo_a    (lo_a),
    .hi_a    (hi_a),
    .cnt_b   (cnt_b),
    .lo_b    (lo_b),
    .hi_b    (hi_b),
    .b_wins  (b_wins),
    .cnt_sum (m_cnt),
    .lo      (m_lo),
    .hi      (m_hi)
  );

  // table write and read selection
  always_comb begin
    p_we    = 1'b0;
    p_waddr = r;
    p_wdata = r;
    p_raddr = r;
    i_we    = 1'b0;
    i_waddr = ra;
    i_wdata = {m_cnt, m_lo, m_hi};
    i_raddr = ra;
    unique case (state)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr;
        p_wdata = clr;
        i_we    = 1'b1;
        i_waddr = clr;
        i_wdata = {CW'(1), clr, clr};
      end
      S_COMP_RD: begin
        p_raddr = cur;
      end
      S_COMP_WR: begin
        // point the node straight at the root
        p_we    = 1'b1;
        p_waddr = cur;
        p_wdata = r;
      end
      S_INFO_B: begin
        i_raddr = rb;
      end
      S_MERGE: begin
        // loser root hangs below the winner, winner takes the merged info
        p_we    = 1'b1;
        p_waddr = b_wins ? ra : rb;
        p_wdata = b_wins ? rb : ra;
        i_we    = 1'b1;
        i_waddr = b_wins ? rb : ra;
      end
      S_MAKE: begin
        p_we    = 1'b1;
        p_waddr = fe;
        p_wdata = fe;
        i_we    = 1'b1;
        i_waddr = fe;
        i_wdata = {CW'(1), fe, fe};
      end
      default: begin
      end
    endcase
  end

  // output word widening or narrowing
  logic [XW-1:0] lo_x;
  logic [XW-1:0] hi_x;

  assign lo_x = XW'(lo_b);
  assign hi_x = XW'(hi_b);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(NUM_ELEMENTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= op;
            phase <= 1'b0;
            fe    <= a_x[AW-1:0];
            r     <= a_x[AW-1:0];
            b_q   <= b_x[AW-1:0];
            if ((op == ufmms_pkg::OP_UNION && a_ok && b_ok) ||
                (op == ufmms_pkg::OP_GET && a_ok)) begin
              state <= S_WALK_RD;
            end else if (op == ufmms_pkg::OP_MAKE && a_ok) begin
              state <= S_MAKE;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (p_rdata == r) begin
            cur   <= fe;
            state <= S_COMP_RD;
          end else begin
            r     <= p_rdata;
            state <= S_WALK_RD;
          end
        end
        S_COMP_RD: begin
          if (cur != r) begin
            state <= S_COMP_WR;
          end else if (!phase) begin
            ra <= r;
            if (op_q == ufmms_pkg::OP_UNION) begin
              phase <= 1'b1;
              fe    <= b_q;
              r     <= b_q;
              state <= S_WALK_RD;
            end else begin
              state <= S_INFO_A;
            end
          end else begin
            rb <= r;
            // both in one set: compression was all there was to do
            state <= (r == ra) ? S_IDLE : S_INFO_A;
          end
        end
        S_COMP_WR: begin
          cur   <= p_rdata;
          state <= S_COMP_RD;
        end
        S_INFO_A: begin
          state <= (op_q == ufmms_pkg::OP_GET) ? S_GET : S_INFO_B;
        end
        S_INFO_B: begin
          info_a <= i_rdata;
          state  <= S_MERGE;
        end
        S_MERGE: begin
          state <= S_IDLE;
        end
        S_GET: begin
          done     <= 1'b1;
          set_min  <= lo_x[EW-1:0];
          set_max  <= hi_x[EW-1:0];
          set_size <= cnt_b;
          state    <= S_IDLE;
        end
        S_MAKE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result only follows the info read of a get
  a_done_after_get: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_GET)
    else $error("result strobe without a get");

  // two distinct roots only ever reach the merge
  a_merge_roots: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (ra != rb))
    else $error("merge of a root with itself");

  // in-range make-set is taken and runs its write
  a_make_runs: assert property (@(posedge clk) disable iff (rst)
    (accept && op == ufmms_pkg::OP_MAKE && a_ok) |=> (state == S_MAKE))
    else $error("make-set dropped");

  // second find only starts for a union
  a_phase_union: assert property (@(posedge clk) disable iff (rst)
    (phase && busy && state != S_CLEAR) |-> (op_q == ufmms_pkg::OP_UNION))
    else $error("second find outside a union");

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM          = ufmms_pkg::DEF_NUM_ELEMENTS;
  localparam int RANDOM_WORDS = 1750;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int SHOW_LIMIT   = 10;

  // op code the block drops without doing anything
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef logic [ufmms_pkg::ELEM_W-1:0] elem_t;
  typedef logic [ufmms_pkg::CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [1:0] op;
    elem_t      a;
    elem_t      b;
  } cmd_t;

  typedef struct packed {
    elem_t lo;
    elem_t hi;
    cnt_t  size;
  } set_info_t;

  // dut ports, every input known from time zero
  logic       clk    = 1'b0;
  logic       rst    = 1'b1;
  logic       start  = 1'b0;
  logic [1:0] op     = ufmms_pkg::OP_UNION;
  elem_t      elem_a = '0;
  elem_t      elem_b = '0;
  logic       busy;
  logic       done;
  elem_t      set_min;
  elem_t      set_max;
  cnt_t       set_size;

  // command words waiting to be driven, and set info still owed by gets
  cmd_t      cmd_queue[$];
  set_info_t info_due[$];

  // shadow copy of the union-find store
  elem_t link_tbl [NUM];
  cnt_t  count_tbl[NUM];
  elem_t lo_tbl   [NUM];
  elem_t hi_tbl   [NUM];

  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        hold_left    = 0;
  int        calm_left    = 0;
  cmd_t      next_cmd;
  set_info_t got_info;
  set_info_t want_info;

  union_find_min_max_size #(
    .NUM_ELEMENTS(NUM)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .elem_a   (elem_a),
    .elem_b   (elem_b),
    .done     (done),
    .set_min  (set_min),
    .set_max  (set_max),
    .set_size (set_size)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow union-find
  // ---------------------------------------------------------------------------

  function automatic bit elem_ok(input elem_t e);
    return int'(e) < NUM;
  endfunction

  task automatic make_singleton(input elem_t e);
    link_tbl[e]  = e;
    count_tbl[e] = cnt_t'(1);
    lo_tbl[e]    = e;
    hi_tbl[e]    = e;
  endtask

  // walk to the root, then point every node on the path straight at it
  function automatic elem_t find_root(input elem_t e);
    elem_t r;
    elem_t cur;
    elem_t nxt;
    int    steps;
    r = e;
    steps = 0;
    while (link_tbl[r] != r && steps < NUM) begin
      r = link_tbl[r];
      steps++;
    end
    cur = e;
    steps = 0;
    while (cur != r && steps < NUM) begin
      nxt = link_tbl[cur];
      link_tbl[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  // union by size, first operand's root keeps a tie, count saturates
  task automatic merge_sets(input elem_t a, input elem_t b);
    elem_t                    ra;
    elem_t                    rb;
    elem_t                    swap;
    logic [ufmms_pkg::CNT_W:0] total;
    ra = find_root(a);
    rb = find_root(b);
    if (ra != rb) begin
      if (count_tbl[ra] < count_tbl[rb]) begin
        swap = ra;
        ra = rb;
        rb = swap;
      end
      link_tbl[rb] = ra;
      total = {1'b0, count_tbl[ra]} + {1'b0, count_tbl[rb]};
      count_tbl[ra] = (total > {1'b0, ufmms_pkg::CNT_MAX}) ? ufmms_pkg::CNT_MAX
                                                           : total[ufmms_pkg::CNT_W-1:0];
      if (lo_tbl[ra] > lo_tbl[rb]) lo_tbl[ra] = lo_tbl[rb];
      if (hi_tbl[ra] < hi_tbl[rb]) hi_tbl[ra] = hi_tbl[rb];
    end
  endtask

  // update the shadow store for one accepted word, queue any result it owes
  task automatic apply_command(input logic [1:0] code, input elem_t a, input elem_t b);
    elem_t     r;
    set_info_t info;
    case (code)
      ufmms_pkg::OP_UNION: begin
        if (elem_ok(a) && elem_ok(b)) merge_sets(a, b);
      end
      ufmms_pkg::OP_GET: begin
        if (elem_ok(a)) begin
          r = find_root(a);
          info.lo   = lo_tbl[r];
          info.hi   = hi_tbl[r];
          info.size = count_tbl[r];
          info_due.push_back(info);
        end
      end
      ufmms_pkg::OP_MAKE: begin
        if (elem_ok(a)) make_singleton(a);
      end
      default: begin
        // unused code, nothing changes
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_cmd(input logic [1:0] code, input int a, input int b);
    cmd_t c;
    c.op = code;
    c.a  = elem_t'(a);
    c.b  = elem_t'(b);
    cmd_queue.push_back(c);
  endtask

  // idle cycles before the next word, with stretches of back-to-back words
  function automatic int next_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 60);
    return $urandom_range(0, 13);
  endfunction

  // a burst of commands over a small window of elements so that sets
  // actually form, merge, get split by make-set and get queried
  task automatic add_episode();
    int span;
    int base;
    int len;
    int k;
    int pick;
    int a;
    int b;
    span = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(2, 8);
    base = $urandom_range(0, NUM - span);
    len  = $urandom_range(15, 50);
    for (k = 0; k < len; k++) begin
      a = base + $urandom_range(0, span - 1);
      b = base + $urandom_range(0, span - 1);
      // occasional stray element from anywhere in the store
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, NUM - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40)      push_cmd(ufmms_pkg::OP_UNION, a, b);
      else if (pick < 75) push_cmd(ufmms_pkg::OP_GET, a, $urandom_range(0, NUM - 1));
      else if (pick < 93) push_cmd(ufmms_pkg::OP_MAKE, a, $urandom_range(0, NUM - 1));
      else                push_cmd(OP_NONE, $urandom_range(0, NUM - 1),
                                   $urandom_range(0, NUM - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one word at a time, start held until busy is low at an edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      for (int i = 0; i < NUM; i++) make_singleton(elem_t'(i));
      hold_left = 0;
    end else begin
      if (start && !busy) apply_command(op, elem_a, elem_b);
      if (!start || !busy) begin
        if (hold_left > 0) begin
          hold_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          next_cmd = cmd_queue.pop_front();
          op       <= next_cmd.op;
          elem_a   <= next_cmd.a;
          elem_b   <= next_cmd.b;
          start    <= 1'b1;
          hold_left = next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done word is checked against the oldest owed get
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && done) begin
      got_info.lo   = set_min;
      got_info.hi   = set_max;
      got_info.size = set_size;
      if (info_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("mismatch: result with no get pending, min %0d max %0d size %0d",
                   set_min, set_max, set_size);
      end else begin
        want_info = info_due.pop_front();
        if (got_info.lo !== want_info.lo || got_info.hi !== want_info.hi ||
            got_info.size !== want_info.size) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("mismatch: min %0d/%0d max %0d/%0d size %0d/%0d (expected/actual)",
                     want_info.lo, got_info.lo, want_info.hi, got_info.hi,
                     want_info.size, got_info.size);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no word taken and no result means a hang
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset, end of run
  // ---------------------------------------------------------------------------

  initial begin
    int target;

    // singletons straight out of the reset sweep, both ends of the range
    push_cmd(ufmms_pkg::OP_GET, 0, 0);
    push_cmd(ufmms_pkg::OP_GET, NUM - 1, NUM - 1);
    // size tie: first operand's root wins
    push_cmd(ufmms_pkg::OP_UNION, 0, NUM - 1);
    push_cmd(ufmms_pkg::OP_GET, NUM - 1, 0);
    // a larger set absorbs a smaller one whichever operand it is
    push_cmd(ufmms_pkg::OP_UNION, 5, 6);
    push_cmd(ufmms_pkg::OP_UNION, 6, 7);
    push_cmd(ufmms_pkg::OP_GET, 7, 0);
    push_cmd(ufmms_pkg::OP_UNION, NUM - 1, 7);
    push_cmd(ufmms_pkg::OP_GET, 0, 0);
    // union inside one set only compresses paths
    push_cmd(ufmms_pkg::OP_UNION, 7, 0);
    push_cmd(ufmms_pkg::OP_UNION, NUM - 1, NUM - 1);
    push_cmd(ufmms_pkg::OP_GET, 6, 0);
    // unused op code is dropped
    push_cmd(OP_NONE, NUM - 1, NUM - 1);
    push_cmd(OP_NONE, 0, 0);
    push_cmd(ufmms_pkg::OP_GET, NUM - 1, 0);
    // make-set on a leaf: it goes alone, the old root keeps its count
    push_cmd(ufmms_pkg::OP_MAKE, 7, NUM - 1);
    push_cmd(ufmms_pkg::OP_GET, 7, 0);
    push_cmd(ufmms_pkg::OP_GET, 0, 0);
    // make-set on the root: nodes still linked to it see its singleton values
    push_cmd(ufmms_pkg::OP_MAKE, 5, 0);
    push_cmd(ufmms_pkg::OP_GET, 6, 0);
    push_cmd(ufmms_pkg::OP_GET, 0, NUM - 1);
    push_cmd(ufmms_pkg::OP_UNION, 6, 7);
    push_cmd(ufmms_pkg::OP_GET, 7, 0);

    target = RANDOM_WORDS;
    while (cmd_queue.size() < target) add_episode();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for every word to go in and every owed result to come back
    @(posedge clk);
    while (cmd_queue.size() != 0 || start || info_due.size() != 0) @(posedge clk);
    // a trailing union or make-set may still be running
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
